/* design/imh_pkg.sv */
// ---------------------------------------------------------------------------
// imh_pkg
// Shared types and fixed field widths for the indexed min-heap.
// ---------------------------------------------------------------------------
`default_nettype none

package imh_pkg;

  localparam int FUNC_BITS    = 2;
  localparam int VERTEX_BITS  = 10;
  localparam int KEY_IN_BITS  = 32;
  localparam int STATUS_BITS  = 2;
  localparam int COUNT_BITS   = 11;
  localparam int VERTEX_SPACE = 1024;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    OP_LOAD    = 2'd0,
    OP_BUILD   = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_CHANGE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    op_t                    op;
    logic [VERTEX_BITS-1:0] vertex;
    logic [KEY_IN_BITS-1:0] key;
  } cmd_t;

endpackage

`default_nettype wire

/* design/imh_if.sv */
// ---------------------------------------------------------------------------
// imh_if
// Valid/ready channels for heap operations and heap results.
// ---------------------------------------------------------------------------
`default_nettype none

interface imh_in_if;
  logic                                valid;
  logic                                ready;
  logic [imh_pkg::FUNC_BITS-1:0]       func;
  logic [imh_pkg::VERTEX_BITS-1:0]     vertex;
  logic signed [imh_pkg::KEY_IN_BITS-1:0] key;

  modport source (output valid, func, vertex, key, input ready);
  modport sink   (input valid, func, vertex, key, output ready);
endinterface

interface imh_out_if;
  logic                                valid;
  logic                                ready;
  logic [imh_pkg::VERTEX_BITS-1:0]     out_vertex;
  logic signed [imh_pkg::KEY_IN_BITS-1:0] out_key;
  logic [imh_pkg::STATUS_BITS-1:0]     status;
  logic [imh_pkg::COUNT_BITS-1:0]      count;

  modport source (output valid, out_vertex, out_key, status, count, input ready);
  modport sink   (input valid, out_vertex, out_key, status, count, output ready);
endinterface

`default_nettype wire

/* design/imh_front.sv */
// ---------------------------------------------------------------------------
// imh_front
// Accepts items, decodes the operation and queues them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module imh_front (
  input  wire logic       clk,
  input  wire logic       rst,
  imh_in_if.sink          in_ch,
  output imh_pkg::cmd_t   head,
  output logic            head_valid,
  input  wire logic       pop
);

  localparam int PW = $clog2(imh_pkg::QUEUE_DEPTH);
  localparam int FW = $clog2(imh_pkg::QUEUE_DEPTH + 1);

  imh_pkg::cmd_t  queue [imh_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [FW-1:0]  fill;
  imh_pkg::cmd_t  cmd_in;
  logic           push;

  always_comb begin
    cmd_in.op     = imh_pkg::op_t'(in_ch.func);
    cmd_in.vertex = in_ch.vertex;
    cmd_in.key    = in_ch.key;
  end

  assign in_ch.ready = (fill != FW'(imh_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (fill != '0);
  assign head        = queue[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) queue[wptr] <= cmd_in;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(imh_pkg::QUEUE_DEPTH)) else $error("queue overfilled");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (fill == $past(fill) - 1'b1)) else $error("fill count slip");

endmodule

`default_nettype wire

/* design/imh_back.sv */
// ---------------------------------------------------------------------------
// imh_back
// Heap sequencer: entry and position memories, sift up/down, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module imh_back #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire imh_pkg::cmd_t head,
  input  wire logic          head_valid,
  output logic               pop,
  imh_out_if.source          out_ch
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = imh_pkg::VERTEX_BITS;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_X_ROOT = 14'b00000000000010,
    S_X_LAST = 14'b00000000000100,
    S_X_MAP  = 14'b00000000001000,
    S_SD_L   = 14'b00000000010000,
    S_SD_R   = 14'b00000000100000,
    S_SD_C   = 14'b00000001000000,
    S_END    = 14'b00000010000000,
    S_B_NEXT = 14'b00000100000000,
    S_B_LOAD = 14'b00001000000000,
    S_C_MAP  = 14'b00010000000000,
    S_C_CHK  = 14'b00100000000000,
    S_SU_P   = 14'b01000000000000,
    S_SU_C   = 14'b10000000000000
  } state_t;

  // memories
  logic [KEY_BITS-1:0] key_mem [CAPACITY];
  logic [VW-1:0]       vtx_mem [CAPACITY];
  logic [IW-1:0]       map_mem [imh_pkg::VERTEX_SPACE];

  logic [IW-1:0]       hraddr, hwaddr;
  logic                hwe;
  logic [KEY_BITS-1:0] hwkey, rd_key;
  logic [VW-1:0]       hwvtx, rd_vtx;
  logic [VW-1:0]       mraddr, mwaddr;
  logic                mwe;
  logic [IW-1:0]       mwdata, map_rd;

  // control and working registers
  state_t              state, state_next;
  logic [CW-1:0]       len, len_next;
  logic [IW-1:0]       pos, bidx;
  logic [KEY_BITS-1:0] cur_key, lent_key, root_key, cmd_k;
  logic [VW-1:0]       cur_vtx, lent_vtx, root_vtx, cmd_v;
  logic                moved, build_mode, is_x, dup_last;
  logic                out_valid;
  logic [VW-1:0]       out_vtx;
  logic [imh_pkg::KEY_IN_BITS-1:0] out_key;
  imh_pkg::status_t    out_status;
  logic [imh_pkg::COUNT_BITS-1:0]  out_count;

  logic                take, fin;
  imh_pkg::status_t    fin_status;
  logic [63:0]         key_in64, root64;
  logic [KEY_BITS-1:0] hkey;
  logic [IW+1:0]       l_w, r_w, len_w;
  logic                l_ok, r_ok, lt_l, lt_r, swap, su_lt;
  logic [KEY_BITS-1:0] b1_key, best_key;
  logic [VW-1:0]       b1_vtx, best_vtx;
  logic [IW-1:0]       best_idx, par;

  assign key_in64 = 64'(signed'(head.key));
  assign hkey     = key_in64[KEY_BITS-1:0];
  assign root64   = 64'(root_key);

  assign l_w   = (IW+2)'({pos, 1'b1});
  assign r_w   = l_w + 1'b1;
  assign len_w = (IW+2)'(len);
  assign l_ok  = l_w < len_w;
  assign r_ok  = r_w < len_w;
  assign par   = IW'((pos - 1'b1) >> 1);

  // child selection; ties keep the entry in place
  assign lt_l     = $signed(lent_key) < $signed(cur_key);
  assign b1_key   = lt_l ? lent_key : cur_key;
  assign b1_vtx   = lt_l ? lent_vtx : cur_vtx;
  assign lt_r     = r_ok && ($signed(rd_key) < $signed(b1_key));
  assign swap     = lt_l || lt_r;
  assign best_key = lt_r ? rd_key : b1_key;
  assign best_vtx = lt_r ? rd_vtx : b1_vtx;
  assign best_idx = lt_r ? r_w[IW-1:0] : l_w[IW-1:0];
  assign su_lt    = $signed(cur_key) < $signed(rd_key);

  assign take = (state == S_IDLE) && head_valid && (!out_valid || out_ch.ready);
  assign pop  = take;

  always_comb begin
    state_next = state;
    len_next   = len;
    fin        = 1'b0;
    fin_status = imh_pkg::ST_OK;
    hwe        = 1'b0;
    hwaddr     = pos;
    hwkey      = cur_key;
    hwvtx      = cur_vtx;
    mwe        = 1'b0;
    mwaddr     = cur_vtx;
    mwdata     = pos;
    hraddr     = '0;
    mraddr     = head.vertex;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (head.op)
            imh_pkg::OP_LOAD: begin
              fin = 1'b1;
              if (len == CW'(CAPACITY)) begin
                fin_status = imh_pkg::ST_FULL;
              end else begin
                hwe      = 1'b1;
                hwaddr   = IW'(len);
                hwkey    = hkey;
                hwvtx    = head.vertex;
                mwe      = 1'b1;
                mwaddr   = head.vertex;
                mwdata   = IW'(len);
                len_next = len + 1'b1;
              end
            end
            imh_pkg::OP_BUILD: state_next = S_B_NEXT;
            imh_pkg::OP_EXTRACT: begin
              if (len == '0) begin
                fin        = 1'b1;
                fin_status = imh_pkg::ST_EMPTY;
              end else begin
                state_next = S_X_ROOT;
              end
            end
            default: state_next = S_C_MAP;
          endcase
        end
      end
      S_X_ROOT: begin
        hraddr     = IW'(len - 1'b1);
        state_next = S_X_LAST;
      end
      S_X_LAST: begin
        // last entry goes to the root
        mwe        = 1'b1;
        mwaddr     = rd_vtx;
        mwdata     = '0;
        len_next   = len - 1'b1;
        state_next = S_X_MAP;
      end
      S_X_MAP: begin
        mwe        = 1'b1;
        mwaddr     = root_vtx;
        mwdata     = IW'(len);
        state_next = S_SD_L;
      end
      S_SD_L: begin
        hraddr     = l_w[IW-1:0];
        state_next = l_ok ? S_SD_R : S_END;
      end
      S_SD_R: begin
        hraddr     = r_w[IW-1:0];
        state_next = S_SD_C;
      end
      S_SD_C: begin
        if (swap) begin
          hwe        = 1'b1;
          hwkey      = best_key;
          hwvtx      = best_vtx;
          mwe        = 1'b1;
          mwaddr     = best_vtx;
          state_next = S_SD_L;
        end else begin
          state_next = S_END;
        end
      end
      S_END: begin
        // moving entry lands; map only touched if it actually moved, and not
        // when the last child lifted carried the same vertex (its map write wins)
        hwe = 1'b1;
        mwe = moved && !dup_last;
        if (build_mode) begin
          state_next = S_B_NEXT;
        end else begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_B_NEXT: begin
        if (bidx == '0) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          hraddr     = IW'(bidx - 1'b1);
          state_next = S_B_LOAD;
        end
      end
      S_B_LOAD: state_next = S_SD_L;
      S_C_MAP: begin
        if (CW'(map_rd) >= len) begin
          fin        = 1'b1;
          fin_status = imh_pkg::ST_ABSENT;
          state_next = S_IDLE;
        end else begin
          hraddr     = map_rd;
          state_next = S_C_CHK;
        end
      end
      S_C_CHK: begin
        if (rd_vtx != cmd_v) begin
          fin        = 1'b1;
          fin_status = imh_pkg::ST_ABSENT;
          state_next = S_IDLE;
        end else begin
          state_next = S_SU_P;
        end
      end
      S_SU_P: begin
        if (pos == '0) begin
          state_next = S_END;
        end else begin
          hraddr     = par;
          state_next = S_SU_C;
        end
      end
      S_SU_C: begin
        if (su_lt) begin
          hwe        = 1'b1;
          hwkey      = rd_key;
          hwvtx      = rd_vtx;
          mwe        = 1'b1;
          mwaddr     = rd_vtx;
          state_next = S_SU_P;
        end else begin
          state_next = S_END;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[hraddr];
    rd_vtx <= vtx_mem[hraddr];
    if (hwe) begin
      key_mem[hwaddr] <= hwkey;
      vtx_mem[hwaddr] <= hwvtx;
    end
  end

  always_ff @(posedge clk) begin
    map_rd <= map_mem[mraddr];
    if (mwe) map_mem[mwaddr] <= mwdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (fin)               out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (take) begin
          cmd_v      <= head.vertex;
          cmd_k      <= hkey;
          is_x       <= (head.op == imh_pkg::OP_EXTRACT);
          build_mode <= (head.op == imh_pkg::OP_BUILD);
          bidx       <= IW'(len >> 1);
        end
      end
      S_X_ROOT: begin
        root_vtx <= rd_vtx;
        root_key <= rd_key;
      end
      S_X_LAST: begin
        cur_vtx  <= rd_vtx;
        cur_key  <= rd_key;
        pos      <= '0;
        moved    <= 1'b0;
        dup_last <= 1'b0;
      end
      S_SD_R: begin
        lent_key <= rd_key;
        lent_vtx <= rd_vtx;
      end
      S_SD_C: begin
        if (swap) begin
          pos      <= best_idx;
          moved    <= 1'b1;
          dup_last <= (best_vtx == cur_vtx);
        end
      end
      S_B_NEXT: begin
        if (bidx != '0) begin
          bidx <= bidx - 1'b1;
          pos  <= IW'(bidx - 1'b1);
        end
      end
      S_B_LOAD: begin
        cur_vtx  <= rd_vtx;
        cur_key  <= rd_key;
        moved    <= 1'b0;
        dup_last <= 1'b0;
      end
      S_C_MAP: pos <= map_rd;
      S_C_CHK: begin
        cur_vtx  <= cmd_v;
        cur_key  <= cmd_k;
        moved    <= 1'b0;
        dup_last <= 1'b0;
      end
      S_SU_C: begin
        if (su_lt) begin
          pos   <= par;
          moved <= 1'b1;
        end
      end
      default: ;
    endcase
    if (fin) begin
      out_status <= fin_status;
      out_count  <= imh_pkg::COUNT_BITS'(len_next);
      if (state == S_END && is_x) begin
        out_vtx <= root_vtx;
        out_key <= root64[imh_pkg::KEY_IN_BITS-1:0];
      end else begin
        out_vtx <= '0;
        out_key <= '0;
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_vertex = out_vtx;
  assign out_ch.out_key    = out_key;
  assign out_ch.status     = out_status;
  assign out_ch.count      = out_count;

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= CW'(CAPACITY)) else $error("heap length beyond capacity");

  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid) else $error("result pending while busy");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (take && head.op == imh_pkg::OP_LOAD && len == CW'(CAPACITY)) |=> $stable(len))
    else $error("full load changed length");

  a_extract_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_X_LAST) |=> (len == $past(len) - 1'b1)) else $error("extract length slip");

endmodule

`default_nettype wire

/* design/indexed_min_heap.sv */
// Load, full load and empty extract complete straight from idle; an absent vertex is found
// at the map read or the entry check; extract reads root and last entry, then sifts down
// a level at a time; change-key sifts up a level at a time. One heap read port, one write port.
// Build sifts down each of count/2 parents in turn, from the last parent to the root.
// One item in execution at a time; a 2-entry queue takes items while it runs.
// Reset clears heap length and control; entry and position memories are not cleared.
// ---------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap with vertex position map: load, build, extract, change key.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  imh_in_if.sink    in_ch,
  imh_out_if.source out_ch
);

  imh_pkg::cmd_t head;
  logic          head_valid;
  logic          pop;

  imh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  imh_back #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

/* tb/sv/heap_checker.sv */
// ---------------------------------------------------------------------------
// heap_checker
// Watches both channels and keeps its own copy of the indexed min-heap.
// Each item taken on the input channel gives one expected result; results
// are compared field by field, in order, with the expected ones.
// ---------------------------------------------------------------------------
`default_nettype none

module heap_checker
  import imh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  imh_in_if         in_ch,
  imh_out_if        out_ch,
  output int        fails,
  output int        pending
);

  localparam int CAP = 1024;

  typedef struct {
    logic [VERTEX_BITS-1:0]        vertex;
    logic signed [KEY_IN_BITS-1:0] key;
    status_t                       status;
    logic [COUNT_BITS-1:0]         count;
  } heap_result_t;

  logic signed [KEY_IN_BITS-1:0] keys [CAP];
  logic [VERTEX_BITS-1:0]        verts [CAP];
  int                            slot_of [VERTEX_SPACE];
  int                            heap_len;
  heap_result_t                  results_due [$];

  initial begin
    fails   = 0;
    pending = 0;
  end

  task automatic report(input string what, input int got, input int want);
    fails++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic void swap_slots(int a, int b);
    logic signed [KEY_IN_BITS-1:0] k;
    logic [VERTEX_BITS-1:0]        v;
    k = keys[a];  v = verts[a];
    keys[a] = keys[b];  verts[a] = verts[b];
    keys[b] = k;  verts[b] = v;
    slot_of[verts[a]] = a;
    slot_of[verts[b]] = b;
  endfunction

  function automatic void sink_entry(int pos, int n);
    int l, r, best;
    forever begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      best = pos;
      if (l < n && keys[l] < keys[best]) best = l;
      if (r < n && keys[r] < keys[best]) best = r;
      if (best == pos) return;
      swap_slots(best, pos);
      pos = best;
    end
  endfunction

  function automatic void raise_entry(int pos);
    int p;
    while (pos > 0) begin
      p = (pos - 1) / 2;
      if (!(keys[pos] < keys[p])) return;
      swap_slots(pos, p);
      pos = p;
    end
  endfunction

  function automatic heap_result_t apply_op(op_t op, logic [VERTEX_BITS-1:0] v,
                                            logic signed [KEY_IN_BITS-1:0] k);
    heap_result_t res;
    int i, pos;
    res.vertex = '0;
    res.key    = '0;
    res.status = ST_OK;
    case (op)
      OP_LOAD: begin
        if (heap_len >= CAP) begin
          res.status = ST_FULL;
        end else begin
          keys[heap_len]  = k;
          verts[heap_len] = v;
          slot_of[v]      = heap_len;
          heap_len++;
        end
      end
      OP_BUILD: begin
        i = heap_len / 2;
        while (i > 0) begin
          i--;
          sink_entry(i, heap_len);
        end
      end
      OP_EXTRACT: begin
        if (heap_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.vertex = verts[0];
          res.key    = keys[0];
          swap_slots(0, heap_len - 1);
          heap_len--;
          sink_entry(0, heap_len);
        end
      end
      default: begin
        pos = slot_of[v];
        if (pos >= heap_len || verts[pos] != v) begin
          res.status = ST_ABSENT;
        end else begin
          keys[pos] = k;
          raise_entry(pos);
        end
      end
    endcase
    res.count = heap_len[COUNT_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    if (rst) begin
      heap_len = 0;
      results_due.delete();
      foreach (slot_of[i]) slot_of[i] = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          report("unexpected result, count", out_ch.count, -1);
        end else begin
          want = results_due.pop_front();
          if (out_ch.out_vertex !== want.vertex)
            report("out_vertex", out_ch.out_vertex, want.vertex);
          if (out_ch.out_key !== want.key)
            report("out_key", out_ch.out_key, want.key);
          if (out_ch.status !== want.status)
            report("status", out_ch.status, want.status);
          if (out_ch.count !== want.count)
            report("count", out_ch.count, want.count);
        end
      end
      if (in_ch.valid && in_ch.ready)
        results_due.push_back(apply_op(op_t'(in_ch.func), in_ch.vertex, in_ch.key));
    end
    pending = results_due.size();
  end

endmodule

`default_nettype wire

/* tb/sv/indexed_min_heap_test.sv */
// ---------------------------------------------------------------------------
// indexed_min_heap_test
// Drives heap operations into the block: a directed opening over the error
// cases and key extremes, one fill to capacity, then random load/build/
// change/extract sequences with runs of extracts. Checking is in heap_checker.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_test;
  import imh_pkg::*;

  localparam int CAP     = 1024;
  localparam int N_ITEMS = 1950;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails, pending;
  int   sent = 0;
  int   heap_len = 0;
  bit   quiet = 1'b0;
  int   stall_left = 0;
  bit   seen [VERTEX_SPACE];
  logic [VERTEX_BITS-1:0] seen_list [$];

  imh_in_if  in_ch ();
  imh_out_if out_ch ();

  indexed_min_heap u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  heap_checker u_chk (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure in short bursts
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_ch.ready = !rst;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(op_t op, logic [VERTEX_BITS-1:0] v, logic [31:0] k);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.func   = op;
    in_ch.vertex = v;
    in_ch.key    = k;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    sent++;
    if (op == OP_LOAD) begin
      if (heap_len < CAP) heap_len++;
      if (!seen[v]) begin
        seen[v] = 1'b1;
        seen_list.push_back(v);
      end
    end else if (op == OP_EXTRACT && heap_len > 0) begin
      heap_len--;
    end
  endtask

  // change-key only on vertices loaded at some point: the map is unset otherwise
  task automatic change_any();
    if (seen_list.size() > 0)
      send(OP_CHANGE, seen_list[$urandom_range(0, seen_list.size() - 1)], pick_key());
  endtask

  task automatic random_op();
    case ($urandom_range(0, 5))
      0, 1: send(OP_LOAD, $urandom_range(0, VERTEX_SPACE - 1), pick_key());
      2, 3: change_any();
      4:    send(OP_EXTRACT, $urandom, $urandom);
      default: send(OP_BUILD, $urandom, $urandom);
    endcase
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.func   = OP_LOAD;
    in_ch.vertex = '0;
    in_ch.key    = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(OP_EXTRACT, 0, 0);
    send(OP_BUILD, 0, 0);
    send(OP_LOAD, 5, 100);
    send(OP_BUILD, 0, 0);
    send(OP_EXTRACT, 0, 0);
    send(OP_CHANGE, 5, 1);             // vertex gone
    send(OP_LOAD, 0, 32'h7fff_ffff);
    send(OP_LOAD, 1023, 32'h8000_0000);
    send(OP_LOAD, 3, 0);
    send(OP_LOAD, 3, 32'hffff_ffff);   // duplicate vertex
    send(OP_LOAD, 7, 32'hffff_ffff);   // equal keys
    send(OP_BUILD, 0, 0);
    send(OP_CHANGE, 1023, 32'h7fff_ffff); // larger key, stays put
    send(OP_CHANGE, 7, 32'h8000_0000);
    send(OP_CHANGE, 3, 5);
    repeat (6) send(OP_EXTRACT, 0, 0);

    // fill to capacity, one load too many, then keep working on a full heap
    while (heap_len < CAP) send(OP_LOAD, $urandom_range(0, VERTEX_SPACE - 1), $urandom);
    send(OP_LOAD, 1023, 32'hffff_ffff);
    send(OP_BUILD, 0, 0);
    repeat (10) change_any();
    repeat (100) send(OP_EXTRACT, 0, 0);

    // sender holds off until the block has caught up
    wait (pending == 0);
    @(negedge clk);

    while (sent < N_ITEMS) begin
      if (sent > N_ITEMS - 200) quiet = 1'b1;
      if ($urandom_range(0, 5) == 0) begin
        repeat (10) random_op();
      end else begin
        repeat ($urandom_range(1, 40)) send(OP_LOAD, $urandom_range(0, VERTEX_SPACE - 1),
                                            pick_key());
        send(OP_BUILD, 0, 0);
        repeat ($urandom_range(0, 20)) begin
          case ($urandom_range(0, 3))
            0:       send(OP_LOAD, $urandom_range(0, VERTEX_SPACE - 1), pick_key());
            1:       send(OP_EXTRACT, 0, 0);
            default: change_any();
          endcase
        end
        while (heap_len > 0 && $urandom_range(0, 9) != 0) send(OP_EXTRACT, 0, 0);
      end
    end

    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fails == 0)
      $display("indexed_min_heap_test: PASS");
    else
      $display("indexed_min_heap_test: FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("indexed_min_heap_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
